// ----- src/tlsr_pkg.sv -----
package tlsr_pkg;

	// command codes carried in tuser
	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	// packed ARGB colour layout
	localparam int COLOR_BITS = 32;
	localparam int CHAN_BITS  = 8;
	localparam int ALPHA_LSB  = 24;
	localparam int RED_LSB    = 16;
	localparam int GREEN_LSB  = 8;
	localparam int BLUE_LSB   = 0;

	// per-item status from the walker to the output stage
	typedef struct packed {
		logic emit;
		logic last;
	} tlsr_ctl_t;

endpackage

// ----- src/thick_line_stamp_rasterizer.sv -----
// Thick line stamp rasterizer. A start word (tuser = 0) loads a segment and
// returns the stamp at its start point; each advance word (tuser = 1) takes one
// Bresenham step and returns the next stamp, tlast marking the stamp on the end
// point. Advance words with no segment running are consumed and return nothing.
// One word is accepted per cycle while the result side is not stalled. Each
// word is held in the input register until the result register is free; its
// stamp is then loaded into the result register. The walker state is updated
// in the same cycle that produces the stamp, so the step adder and end-point
// compare set the clock rate.
module thick_line_stamp_rasterizer #(
	parameter int COORD_BITS = 16,
	parameter int THICK_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// lowest bit up: start_x, start_y, end_x, end_y, thickness, argb colour, zero fill
	input  logic [((4*COORD_BITS+THICK_BITS+tlsr_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
	// cmd
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// lowest bit up: stamp_x, stamp_y, stamp_size, alpha, red, green, blue, zero fill
	output logic [((2*COORD_BITS+2+THICK_BITS+4*tlsr_pkg::CHAN_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic m_axis_tlast
);
	import tlsr_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int T     = THICK_BITS;
	localparam int IUSED = 4*C + T + COLOR_BITS;
	localparam int OUSED = 2*(C+1) + T + 4*CHAN_BITS;
	localparam int ODW   = ((OUSED + 7) / 8) * 8;

	logic                  in_valid_s1;
	logic                  cmd_s1;
	logic [IUSED-1:0]      data_s1;
	logic                  out_valid_s2;
	logic                  last_s2;
	logic [OUSED-1:0]      data_s2;
	logic                  out_free, fire;

	logic [C:0]            stamp_x, stamp_y;
	logic [T-1:0]          stamp_size;
	logic [COLOR_BITS-1:0] stamp_color;
	tlsr_ctl_t             ctl;

	assign out_free      = !out_valid_s2 || m_axis_tready;
	assign fire          = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			data_s1 <= s_axis_tdata[IUSED-1:0];
		end
	end

	tlsr_walker #(
		.COORD_BITS(COORD_BITS),
		.THICK_BITS(THICK_BITS)
	) u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (fire),
		.cmd        (cmd_s1),
		.start_x    (data_s1[C-1:0]),
		.start_y    (data_s1[2*C-1:C]),
		.end_x      (data_s1[3*C-1:2*C]),
		.end_y      (data_s1[4*C-1:3*C]),
		.thickness  (data_s1[4*C+T-1:4*C]),
		.argb       (data_s1[IUSED-1:4*C+T]),
		.stamp_x    (stamp_x),
		.stamp_y    (stamp_y),
		.stamp_size (stamp_size),
		.stamp_color(stamp_color),
		.ctl        (ctl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (fire) begin
			out_valid_s2 <= ctl.emit;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl.emit) begin
			last_s2 <= ctl.last;
			data_s2 <= {stamp_color[BLUE_LSB  +: CHAN_BITS],
			            stamp_color[GREEN_LSB +: CHAN_BITS],
			            stamp_color[RED_LSB   +: CHAN_BITS],
			            stamp_color[ALPHA_LSB +: CHAN_BITS],
			            stamp_size, stamp_y, stamp_x};
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tlast  = last_s2;
	assign m_axis_tdata  = {{(ODW-OUSED){1'b0}}, data_s2};

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctl.emit) |=> (m_axis_tvalid && (m_axis_tlast == $past(ctl.last))))
		else $error("stamp not presented after step");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.last |-> ctl.emit)
		else $error("last flag without a stamp");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !out_free) |=> (in_valid_s1 && $stable(cmd_s1) && $stable(data_s1)))
		else $error("input word lost while result stage full");

endmodule

// ----- src/tlsr_walker.sv -----
module tlsr_walker #(
	parameter int COORD_BITS = 16,
	parameter int THICK_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step_en,
	input  logic                           cmd,
	input  logic [COORD_BITS-1:0]          start_x,
	input  logic [COORD_BITS-1:0]          start_y,
	input  logic [COORD_BITS-1:0]          end_x,
	input  logic [COORD_BITS-1:0]          end_y,
	input  logic [THICK_BITS-1:0]          thickness,
	input  logic [tlsr_pkg::COLOR_BITS-1:0] argb,
	output logic [COORD_BITS:0]            stamp_x,
	output logic [COORD_BITS:0]            stamp_y,
	output logic [THICK_BITS-1:0]          stamp_size,
	output logic [tlsr_pkg::COLOR_BITS-1:0] stamp_color,
	output tlsr_pkg::tlsr_ctl_t            ctl
);
	import tlsr_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int EW = COORD_BITS + 3;
	localparam int SW = ((COORD_BITS > THICK_BITS) ? COORD_BITS : THICK_BITS) + 1;

	logic signed [C-1:0]    cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic        [C:0]      abs_dx_q;
	logic signed [C+1:0]    neg_abs_dy_q;
	logic                   step_x_neg_q, step_y_neg_q;
	logic signed [EW-1:0]   err_q;
	logic [THICK_BITS-1:0]  side_q;
	logic [COLOR_BITS-1:0]  color_q;
	logic                   active_q;

	logic signed [C-1:0]    cur_x_n, cur_y_n, tgt_x_n, tgt_y_n;
	logic        [C:0]      abs_dx_n;
	logic signed [C+1:0]    neg_abs_dy_n;
	logic                   step_x_neg_n, step_y_neg_n;
	logic signed [EW-1:0]   err_n;
	logic [THICK_BITS-1:0]  side_n;
	logic [COLOR_BITS-1:0]  color_n;
	logic                   active_n;

	logic signed [C:0]      dx, dy;
	logic        [C:0]      abs_dy;
	logic signed [EW:0]     e2, neg_ext, abs_ext, err_sum;
	logic                   take_x, take_y, at_end;
	logic [THICK_BITS-1:0]  half;
	logic signed [SW-1:0]   sx_full, sy_full;

	always_comb begin
		cur_x_n      = cur_x_q;
		cur_y_n      = cur_y_q;
		tgt_x_n      = tgt_x_q;
		tgt_y_n      = tgt_y_q;
		abs_dx_n     = abs_dx_q;
		neg_abs_dy_n = neg_abs_dy_q;
		step_x_neg_n = step_x_neg_q;
		step_y_neg_n = step_y_neg_q;
		err_n        = err_q;
		side_n       = side_q;
		color_n      = color_q;
		active_n     = active_q;
		ctl          = '0;

		dx      = $signed({end_x[C-1], end_x}) - $signed({start_x[C-1], start_x});
		dy      = $signed({end_y[C-1], end_y}) - $signed({start_y[C-1], start_y});
		abs_dy  = dy[C] ? (C+1)'(0) - dy : dy;
		e2      = {err_q, 1'b0};
		neg_ext = {{(EW-C-1){neg_abs_dy_q[C+1]}}, neg_abs_dy_q};
		abs_ext = $signed({{(EW-C){1'b0}}, abs_dx_q});
		take_x  = (e2 >= neg_ext);
		take_y  = (e2 <= abs_ext);
		err_sum = {err_q[EW-1], err_q} + (take_x ? neg_ext : '0) + (take_y ? abs_ext : '0);

		if (cmd == CMD_START) begin
			cur_x_n      = $signed(start_x);
			cur_y_n      = $signed(start_y);
			tgt_x_n      = $signed(end_x);
			tgt_y_n      = $signed(end_y);
			side_n       = (thickness == '0) ? THICK_BITS'(1) : thickness;
			color_n      = argb;
			abs_dx_n     = dx[C] ? (C+1)'(0) - dx : dx;
			neg_abs_dy_n = (C+2)'(0) - $signed({1'b0, abs_dy});
			step_x_neg_n = !($signed(start_x) < $signed(end_x));
			step_y_neg_n = !($signed(start_y) < $signed(end_y));
			err_n        = $signed({{(EW-C-1){1'b0}}, abs_dx_n})
				+ {{(EW-C-2){neg_abs_dy_n[C+1]}}, neg_abs_dy_n};
			ctl.emit     = 1'b1;
		end else if (active_q) begin
			// one Bresenham step: either axis or both
			if (take_x) begin
				cur_x_n = cur_x_q + (step_x_neg_q ? '1 : C'(1));
			end
			if (take_y) begin
				cur_y_n = cur_y_q + (step_y_neg_q ? '1 : C'(1));
			end
			err_n    = err_sum[EW-1:0];
			ctl.emit = 1'b1;
		end

		at_end = (cur_x_n == tgt_x_n) && (cur_y_n == tgt_y_n);
		if (ctl.emit) begin
			active_n = !at_end;
			ctl.last = at_end;
		end

		// corner of the stamp: point minus half the side, rounded down
		half        = side_n >> 1;
		sx_full     = {{(SW-C){cur_x_n[C-1]}}, cur_x_n} - $signed({{(SW-THICK_BITS){1'b0}}, half});
		sy_full     = {{(SW-C){cur_y_n[C-1]}}, cur_y_n} - $signed({{(SW-THICK_BITS){1'b0}}, half});
		stamp_x     = sx_full[C:0];
		stamp_y     = sy_full[C:0];
		stamp_size  = side_n;
		stamp_color = color_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			tgt_x_q      <= '0;
			tgt_y_q      <= '0;
			abs_dx_q     <= '0;
			neg_abs_dy_q <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			err_q        <= '0;
			side_q       <= THICK_BITS'(1);
			color_q      <= '0;
			active_q     <= 1'b0;
		end else if (step_en) begin
			cur_x_q      <= cur_x_n;
			cur_y_q      <= cur_y_n;
			tgt_x_q      <= tgt_x_n;
			tgt_y_q      <= tgt_y_n;
			abs_dx_q     <= abs_dx_n;
			neg_abs_dy_q <= neg_abs_dy_n;
			step_x_neg_q <= step_x_neg_n;
			step_y_neg_q <= step_y_neg_n;
			err_q        <= err_n;
			side_q       <= side_n;
			color_q      <= color_n;
			active_q     <= active_n;
		end
	end

endmodule

// ----- sim/thick_line_stamp_rasterizer_tb.sv -----
`timescale 1ns / 1ps

module thick_line_stamp_rasterizer_tb;
	import tlsr_pkg::*;

	localparam int IN_W  = ((4*16 + 8 + COLOR_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((2*16 + 2 + 8 + 4*CHAN_BITS + 7) / 8) * 8;
	localparam int LIMIT = 400000;

	typedef struct packed {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic [7:0]         size;
		logic [7:0]         a;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
		logic               last;
	} stamp_t;

	function automatic int iabs(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic string fmt_stamp(stamp_t s);
		return $sformatf("x=%0d y=%0d size=%0d argb=%02h%02h%02h%02h last=%0b",
			s.x, s.y, s.size, s.a, s.r, s.g, s.b, s.last);
	endfunction

	// Bresenham walker mirror plus the queue of stamps still owed by the block
	class stamp_scoreboard;
		int cur_x, cur_y, tgt_x, tgt_y;
		int dx_abs, dy_neg, err_acc;
		bit x_back, y_back, walking;
		bit [7:0] side;
		bit [31:0] colour;
		stamp_t owed[$];
		int mismatches;
		int stamps_due;

		function new();
			side = 8'd1;
		endfunction

		function void note_word(logic cmd, logic [IN_W-1:0] w);
			int e2;
			int half;
			stamp_t s;
			if (cmd == CMD_START) begin
				cur_x = $signed(w[15:0]);
				cur_y = $signed(w[31:16]);
				tgt_x = $signed(w[47:32]);
				tgt_y = $signed(w[63:48]);
				side = (w[71:64] == 8'd0) ? 8'd1 : w[71:64];
				colour = w[103:72];
				dx_abs = iabs(tgt_x - cur_x);
				x_back = !(cur_x < tgt_x);
				dy_neg = -iabs(tgt_y - cur_y);
				y_back = !(cur_y < tgt_y);
				err_acc = dx_abs + dy_neg;
			end else begin
				// nothing to advance: word is swallowed
				if (!walking)
					return;
				e2 = 2 * err_acc;
				if (e2 >= dy_neg) begin
					err_acc += dy_neg;
					cur_x += x_back ? -1 : 1;
				end
				if (e2 <= dx_abs) begin
					err_acc += dx_abs;
					cur_y += y_back ? -1 : 1;
				end
			end
			walking = !(cur_x == tgt_x && cur_y == tgt_y);
			half = side >> 1;
			s.x = 17'(cur_x - half);
			s.y = 17'(cur_y - half);
			s.size = side;
			s.a = colour[ALPHA_LSB +: CHAN_BITS];
			s.r = colour[RED_LSB +: CHAN_BITS];
			s.g = colour[GREEN_LSB +: CHAN_BITS];
			s.b = colour[BLUE_LSB +: CHAN_BITS];
			s.last = !walking;
			owed.push_back(s);
			stamps_due++;
		endfunction

		function void check_stamp(logic [OUT_W-1:0] w, logic tl);
			stamp_t got;
			stamp_t want;
			got.x = w[16:0];
			got.y = w[33:17];
			got.size = w[41:34];
			got.a = w[49:42];
			got.r = w[57:50];
			got.g = w[65:58];
			got.b = w[73:66];
			got.last = tl;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected stamp: %s", fmt_stamp(got));
				return;
			end
			want = owed.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.size !== want.size ||
					got.a !== want.a || got.r !== want.r || got.g !== want.g ||
					got.b !== want.b || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("stamp mismatch: expected %s, got %s",
						fmt_stamp(want), fmt_stamp(got));
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata;
	logic             s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             m_axis_tlast;

	stamp_scoreboard sb = new();
	bit idle_on = 1'b1;
	bit stall_req = 1'b0;
	int cycle_count = 0;

	thick_line_stamp_rasterizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_word(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_stamp(m_axis_tdata, m_axis_tlast);
		end
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin
		m_axis_tready <= 1'b0;
		repeat (3) @(posedge clk);
		forever begin
			if (stall_req) begin
				stall_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	function automatic logic [IN_W-1:0] junk_word();
		return IN_W'({$urandom, $urandom, $urandom, $urandom});
	endfunction

	// keep the end point in the signed 16-bit range: step the other way if needed
	function automatic int end_near(int s, int d);
		int e;
		e = s + d;
		if (e > 32767 || e < -32768)
			e = s - d;
		return e;
	endfunction

	function automatic int rand_coord();
		return $signed(16'($urandom));
	endfunction

	task automatic push_word(logic cmd, logic [IN_W-1:0] w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= w;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic draw_segment(int sx, int sy, int ex, int ey, logic [7:0] th,
			logic [31:0] col, int n_adv);
		push_word(CMD_START, {col, th, 16'(ey), 16'(ex), 16'(sy), 16'(sx)});
		repeat (n_adv) push_word(CMD_ADVANCE, junk_word());
	endtask

	initial begin
		int sx, sy, ex, ey, dx, dy, n, pick;
		bit stall_done;
		stall_done = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser <= CMD_START;
		s_axis_tdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// advance with nothing loaded
		push_word(CMD_ADVANCE, junk_word());
		// zero-length segment at the corners of the range, zero thickness
		draw_segment(32767, -32768, 32767, -32768, 8'd0, 32'hffff_ffff, 1);
		// longest possible diagonal, dropped part-way by a fresh start
		draw_segment(-32768, -32768, 32767, 32767, 8'd255, 32'h0000_0000, 2);
		draw_segment(5, 5, 8, -2, 8'd2, 32'ha55a_3cc3, 8);
		draw_segment(0, 0, -4, 3, 8'd255, 32'h8001_7ffe, 4);
		draw_segment(32767, 32767, 32764, 32767, 8'd254, 32'h1234_5678, 3);

		while (sb.stamps_due < 1100) begin
			if (sb.stamps_due > 950)
				idle_on = 1'b0;
			if (!stall_done && sb.stamps_due > 400) begin
				stall_req = 1'b1;
				stall_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			sx = rand_coord();
			sy = rand_coord();
			if (pick < 80) begin
				dx = $urandom_range(0, 24);
				dy = $urandom_range(0, 24);
				if ($urandom_range(0, 1))
					dx = -dx;
				if ($urandom_range(0, 1))
					dy = -dy;
				ex = end_near(sx, dx);
				ey = end_near(sy, dy);
				n = (iabs(dx) > iabs(dy)) ? iabs(dx) : iabs(dy);
				if ($urandom_range(0, 6) == 0)
					n = $urandom_range(0, n);
				else if ($urandom_range(0, 4) == 0)
					n += $urandom_range(1, 2);
				draw_segment(sx, sy, ex, ey, 8'($urandom), $urandom, n);
			end else if (pick < 90) begin
				draw_segment(sx, sy, rand_coord(), rand_coord(), 8'($urandom), $urandom,
					$urandom_range(0, 5));
			end else begin
				repeat ($urandom_range(1, 3)) push_word(CMD_ADVANCE, junk_word());
			end
		end
		s_axis_tvalid <= 1'b0;

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
